FILE: hw/rtl/gbmo_pkg.sv
// ----------------------------------------------------------------------------
// gbmo_pkg
// Shared types, register indexes and fixed-point constants for the GBM path
// unit: configuration layout, datapath operations and controller states.
// ----------------------------------------------------------------------------
package gbmo_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PRICE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXERCISE_PRICE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DRIFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_VOLATILITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTION_IS_PUT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_PATH  = 3'd6;

    // register reset values
    localparam logic [31:0] RST_INITIAL_PRICE   = 32'd6553600;
    localparam logic [31:0] RST_EXERCISE_PRICE  = 32'd6553600;
    localparam logic [31:0] RST_STEP_DRIFT      = 32'd738198;
    localparam logic [30:0] RST_STEP_VOLATILITY = 31'd26843546;
    localparam logic [31:0] RST_DISCOUNT_FACTOR = 32'd1943123559;
    localparam logic        RST_OPTION_IS_PUT   = 1'b0;
    localparam logic [15:0] RST_STEPS_PER_PATH  = 16'd100;

    // fixed-point constants
    localparam logic [31:0]        ONE_Q30      = 32'h4000_0000;
    localparam logic [29:0]        LN2_Q30      = 30'd744261118;
    localparam logic signed [29:0] LOG2E_Q28    = 30'sd387270501;
    localparam logic signed [36:0] X_LIMIT      = 37'sd17179869184;  // 16.0 in Q30
    localparam logic [37:0]        N_BIAS_Q30   = 38'h8_0000_0000;   // 32.0 in Q30
    localparam logic signed [7:0]  N_BIAS       = 8'sd32;
    localparam logic signed [7:0]  SHIFT_BASE   = 8'sd30;
    localparam logic [3:0]         SERIES_TERMS = 4'd10;
    localparam logic [31:0]        U32_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] initial_price;
        logic [31:0] exercise_price;
        logic [31:0] step_drift;
        logic [30:0] step_volatility;
        logic [31:0] discount_factor;
        logic        option_is_put;
        logic [15:0] steps_per_path;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_VZ,
        DP_X,
        DP_Y,
        DP_F,
        DP_T,
        DP_H1,
        DP_H2,
        DP_H3,
        DP_P,
        DP_S,
        DP_D,
        DP_M,
        DP_O
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VZ,
        ST_X,
        ST_Y,
        ST_F,
        ST_T,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_P,
        ST_S,
        ST_D,
        ST_M,
        ST_O
    } ctrl_state_t;

    typedef struct packed {
        logic last_term;   // Horner loop on its final term
        logic path_end;    // step under way closes the path
        logic out_free;    // output register can take a result
    } dp_status_t;

    // floor(2^32 / k), k = 1 kept one short so it fits 32 bits; the
    // quotient estimate is corrected afterwards
    function automatic logic [31:0] recip_q32(input logic [3:0] k);
        logic [31:0] m;
        unique case (k)
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/gbmo_cfg_regs.sv
// ----------------------------------------------------------------------------
// gbmo_cfg_regs
// Configuration register file, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module gbmo_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbmo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output gbmo_pkg::cfg_t                 cfg
);

    gbmo_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_price   <= gbmo_pkg::RST_INITIAL_PRICE;
            cfg_reg.exercise_price  <= gbmo_pkg::RST_EXERCISE_PRICE;
            cfg_reg.step_drift      <= gbmo_pkg::RST_STEP_DRIFT;
            cfg_reg.step_volatility <= gbmo_pkg::RST_STEP_VOLATILITY;
            cfg_reg.discount_factor <= gbmo_pkg::RST_DISCOUNT_FACTOR;
            cfg_reg.option_is_put   <= gbmo_pkg::RST_OPTION_IS_PUT;
            cfg_reg.steps_per_path  <= gbmo_pkg::RST_STEPS_PER_PATH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                gbmo_pkg::CFG_INITIAL_PRICE:   cfg_reg.initial_price   <= cfg_data;
                gbmo_pkg::CFG_EXERCISE_PRICE:  cfg_reg.exercise_price  <= cfg_data;
                gbmo_pkg::CFG_STEP_DRIFT:      cfg_reg.step_drift      <= cfg_data;
                gbmo_pkg::CFG_STEP_VOLATILITY: cfg_reg.step_volatility <= cfg_data[30:0];
                gbmo_pkg::CFG_DISCOUNT_FACTOR: cfg_reg.discount_factor <= cfg_data;
                gbmo_pkg::CFG_OPTION_IS_PUT:   cfg_reg.option_is_put   <= cfg_data[0];
                gbmo_pkg::CFG_STEPS_PER_PATH:  cfg_reg.steps_per_path  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/gbmo_ctrl.sv
// ----------------------------------------------------------------------------
// gbmo_ctrl
// Sequencer for one price step: exponent, range reduction, Horner series,
// price update and, at the end of a path, payoff and result hand-off.
// ----------------------------------------------------------------------------
module gbmo_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gbmo_pkg::dp_status_t status,
    output gbmo_pkg::dp_op_t     op
);

    gbmo_pkg::ctrl_state_t state_reg;
    gbmo_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbmo_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbmo_pkg::ST_IDLE: if (s_valid) state_next = gbmo_pkg::ST_VZ;
            gbmo_pkg::ST_VZ:   state_next = gbmo_pkg::ST_X;
            gbmo_pkg::ST_X:    state_next = gbmo_pkg::ST_Y;
            gbmo_pkg::ST_Y:    state_next = gbmo_pkg::ST_F;
            gbmo_pkg::ST_F:    state_next = gbmo_pkg::ST_T;
            gbmo_pkg::ST_T:    state_next = gbmo_pkg::ST_H1;
            gbmo_pkg::ST_H1:   state_next = gbmo_pkg::ST_H2;
            gbmo_pkg::ST_H2:   state_next = gbmo_pkg::ST_H3;
            gbmo_pkg::ST_H3: begin
                state_next = status.last_term ? gbmo_pkg::ST_P : gbmo_pkg::ST_H1;
            end
            gbmo_pkg::ST_P:    state_next = gbmo_pkg::ST_S;
            gbmo_pkg::ST_S: begin
                state_next = status.path_end ? gbmo_pkg::ST_D : gbmo_pkg::ST_IDLE;
            end
            gbmo_pkg::ST_D:    state_next = gbmo_pkg::ST_M;
            gbmo_pkg::ST_M:    state_next = gbmo_pkg::ST_O;
            gbmo_pkg::ST_O:    if (status.out_free) state_next = gbmo_pkg::ST_IDLE;
            default:           state_next = gbmo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        op      = gbmo_pkg::DP_NONE;
        unique case (state_reg)
            gbmo_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                op      = s_valid ? gbmo_pkg::DP_LOAD : gbmo_pkg::DP_NONE;
            end
            gbmo_pkg::ST_VZ: op = gbmo_pkg::DP_VZ;
            gbmo_pkg::ST_X:  op = gbmo_pkg::DP_X;
            gbmo_pkg::ST_Y:  op = gbmo_pkg::DP_Y;
            gbmo_pkg::ST_F:  op = gbmo_pkg::DP_F;
            gbmo_pkg::ST_T:  op = gbmo_pkg::DP_T;
            gbmo_pkg::ST_H1: op = gbmo_pkg::DP_H1;
            gbmo_pkg::ST_H2: op = gbmo_pkg::DP_H2;
            gbmo_pkg::ST_H3: op = gbmo_pkg::DP_H3;
            gbmo_pkg::ST_P:  op = gbmo_pkg::DP_P;
            gbmo_pkg::ST_S:  op = gbmo_pkg::DP_S;
            gbmo_pkg::ST_D:  op = gbmo_pkg::DP_D;
            gbmo_pkg::ST_M:  op = gbmo_pkg::DP_M;
            gbmo_pkg::ST_O:  op = status.out_free ? gbmo_pkg::DP_O : gbmo_pkg::DP_NONE;
            default:         op = gbmo_pkg::DP_NONE;
        endcase
    end

endmodule

FILE: hw/rtl/gbmo_datapath.sv
// ----------------------------------------------------------------------------
// gbmo_datapath
// Fixed-point arithmetic for one GBM step and the option payoff, plus the
// path state and the output register.
// ----------------------------------------------------------------------------
module gbmo_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gbmo_pkg::cfg_t       cfg,
    input  gbmo_pkg::dp_op_t     op,
    output gbmo_pkg::dp_status_t status,
    input  logic signed [15:0]   s_normal_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_payoff,
    output logic [31:0]          m_final_price
);

    logic signed [15:0] z_reg;
    logic [31:0]        base_reg;
    logic signed [47:0] vz_reg;
    logic signed [35:0] x_reg;
    logic signed [65:0] ymul_reg;
    logic signed [7:0]  n_reg;
    logic [29:0]        f_reg;
    logic [29:0]        t_reg;
    logic [31:0]        r_reg;
    logic [3:0]         k_reg;
    logic [61:0]        hprod_reg;
    logic [31:0]        q_reg;
    logic [63:0]        qm_reg;
    logic [63:0]        pprod_reg;
    logic [31:0]        price_reg;
    logic [31:0]        diff_reg;
    logic [63:0]        dprod_reg;
    logic [31:0]        payoff_reg;
    logic [31:0]        final_reg;
    logic [15:0]        steps_done_reg;
    logic               m_valid_reg;

    logic signed [47:0] vz_next;
    logic signed [36:0] x_sum;
    logic signed [35:0] x_next;
    logic signed [65:0] ymul_next;
    logic [37:0]        u_next;
    logic signed [7:0]  n_next;
    logic [59:0]        tmul;
    logic [29:0]        t_next;
    logic [61:0]        hprod_next;
    logic [31:0]        q_next;
    logic [63:0]        qm_next;
    logic [31:0]        qe;
    logic [35:0]        qk;
    logic [35:0]        rem;
    logic [31:0]        r_next;
    logic [63:0]        pprod_next;
    logic signed [7:0]  sh;
    logic [63:0]        shifted;
    logic [31:0]        price_next;
    logic [15:0]        steps_inc;
    logic [15:0]        limit;
    logic               path_end;
    logic [15:0]        steps_next;
    logic [31:0]        diff_next;
    logic [63:0]        dprod_next;
    logic [31:0]        payoff_next;
    logic               out_free;

    // exponent: drift + floor(vol * z / 2^12), clamped to +/-16
    assign vz_next = $signed({1'b0, cfg.step_volatility}) * z_reg;
    assign x_sum   = $signed({{5{cfg.step_drift[31]}}, cfg.step_drift})
                   + $signed({vz_reg[47], vz_reg[47:12]});

    always_comb begin
        priority if (x_sum > gbmo_pkg::X_LIMIT) begin
            x_next = gbmo_pkg::X_LIMIT[35:0];
        end else if (x_sum < -gbmo_pkg::X_LIMIT) begin
            x_next = 36'(-gbmo_pkg::X_LIMIT);
        end else begin
            x_next = x_sum[35:0];
        end
    end

    // base-2 split: y = x * log2(e), integer part n, fraction f
    assign ymul_next = x_reg * gbmo_pkg::LOG2E_Q28;
    assign u_next    = ymul_reg[65:28] + gbmo_pkg::N_BIAS_Q30;
    assign n_next    = $signed(u_next[37:30]) - gbmo_pkg::N_BIAS;
    assign tmul      = f_reg * gbmo_pkg::LN2_Q30;
    assign t_next    = tmul[59:30];

    // Horner term: r = 1 + floor(floor(r * t / 2^30) / k), divide by
    // reciprocal multiply, then one correction step
    assign hprod_next = r_reg * t_reg;
    assign q_next     = hprod_reg[61:30];
    assign qm_next    = q_next * gbmo_pkg::recip_q32(k_reg);
    assign qe         = qm_reg[63:32];
    assign qk         = {4'd0, qe} * {32'd0, k_reg};
    assign rem        = {4'd0, q_reg} - qk;
    assign r_next     = gbmo_pkg::ONE_Q30
                      + ((rem >= {32'd0, k_reg}) ? qe + 32'd1 : qe);

    // price * e^t * 2^n, saturating
    assign pprod_next = base_reg * r_reg;
    assign sh         = gbmo_pkg::SHIFT_BASE - n_reg;
    assign shifted    = pprod_reg >> sh[5:0];

    always_comb begin
        priority if (pprod_reg == 64'd0) begin
            price_next = 32'd0;
        end else if (n_reg > gbmo_pkg::SHIFT_BASE) begin
            price_next = gbmo_pkg::U32_MAX;
        end else if (sh[7:6] != 2'd0) begin
            price_next = 32'd0;
        end else if (shifted[63:32] != 32'd0) begin
            price_next = gbmo_pkg::U32_MAX;
        end else begin
            price_next = shifted[31:0];
        end
    end

    // path bookkeeping; a step count that wraps to zero also closes the path
    assign steps_inc  = steps_done_reg + 16'd1;
    assign limit      = (cfg.steps_per_path == 16'd0) ? 16'd1 : cfg.steps_per_path;
    assign path_end   = (steps_inc == 16'd0) || (steps_inc >= limit);
    assign steps_next = path_end ? 16'd0 : steps_inc;

    always_comb begin
        diff_next = 32'd0;
        if (cfg.option_is_put) begin
            if (cfg.exercise_price > price_reg) diff_next = cfg.exercise_price - price_reg;
        end else begin
            if (price_reg > cfg.exercise_price) diff_next = price_reg - cfg.exercise_price;
        end
    end

    assign dprod_next  = diff_reg * cfg.discount_factor;
    assign payoff_next = dprod_reg[63] ? gbmo_pkg::U32_MAX : dprod_reg[62:31];

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        unique case (op)
            gbmo_pkg::DP_LOAD: begin
                z_reg    <= s_normal_sample;
                base_reg <= (steps_done_reg == 16'd0) ? cfg.initial_price : price_reg;
            end
            gbmo_pkg::DP_VZ: vz_reg   <= vz_next;
            gbmo_pkg::DP_X:  x_reg    <= x_next;
            gbmo_pkg::DP_Y:  ymul_reg <= ymul_next;
            gbmo_pkg::DP_F: begin
                n_reg <= n_next;
                f_reg <= u_next[29:0];
            end
            gbmo_pkg::DP_T: begin
                t_reg <= t_next;
                r_reg <= gbmo_pkg::ONE_Q30;
                k_reg <= gbmo_pkg::SERIES_TERMS;
            end
            gbmo_pkg::DP_H1: hprod_reg <= hprod_next;
            gbmo_pkg::DP_H2: begin
                q_reg  <= q_next;
                qm_reg <= qm_next;
            end
            gbmo_pkg::DP_H3: begin
                r_reg <= r_next;
                k_reg <= k_reg - 4'd1;
            end
            gbmo_pkg::DP_P: pprod_reg <= pprod_next;
            gbmo_pkg::DP_S: price_reg <= price_next;
            gbmo_pkg::DP_D: diff_reg  <= diff_next;
            gbmo_pkg::DP_M: dprod_reg <= dprod_next;
            gbmo_pkg::DP_O: begin
                payoff_reg <= payoff_next;
                final_reg  <= price_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_done_reg <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (op == gbmo_pkg::DP_S) steps_done_reg <= steps_next;
            if (op == gbmo_pkg::DP_O) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last_term = (k_reg == 4'd1);
    assign status.path_end  = path_end;
    assign status.out_free  = out_free;

    assign m_valid       = m_valid_reg;
    assign m_payoff      = payoff_reg;
    assign m_final_price = final_reg;

endmodule

FILE: hw/rtl/gbm_option_payoff_path_unit.sv
// ----------------------------------------------------------------------------
// gbm_option_payoff_path_unit
// One GBM price step per sample; at path end, discounted call/put payoff.
// ----------------------------------------------------------------------------
// s_ready drops on acceptance and returns once the step has run the states VZ,
// X, Y, F, T, the ten-term Horner series (H1, H2, H3 a term), P and S.
// A path-closing step adds the payoff states D, M and O: the result becomes valid,
// and s_ready returns, as O completes, which waits for a free output register;
// a result may wait there while the next path starts.
// Reset (synchronous, aresetn low): registers to defaults, path restarted,
// no result pending.
module gbm_option_payoff_path_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_normal_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_payoff,
    output logic [31:0]                    m_final_price,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbmo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    gbmo_pkg::cfg_t       cfg;
    gbmo_pkg::dp_op_t     op;
    gbmo_pkg::dp_status_t status;

    gbmo_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbmo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    gbmo_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .op              (op),
        .status          (status),
        .s_normal_sample (s_normal_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payoff        (m_payoff),
        .m_final_price   (m_final_price)
    );

endmodule

FILE: hw/rtl/gbmo_checker.sv
// ----------------------------------------------------------------------------
// gbmo_checker
// Port-level checks on the GBM path unit, bound to the top level.
// ----------------------------------------------------------------------------
module gbmo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_payoff,
    input logic [31:0] m_final_price
);

    // reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payoff) && $stable(m_final_price))
        else $error("result changed while stalled");

    // a step keeps the unit busy (s_ready low) after its transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input taken again too soon");

    // a new result only appears after the unit has been busy
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a busy cycle");

endmodule

bind gbm_option_payoff_path_unit gbmo_checker u_gbmo_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_payoff      (m_payoff),
    .m_final_price (m_final_price)
);
